// File: rtl/icsp_serial_programmer_master_top_defines.svh
// Assertion macros shared by the checker of the serial programming master.
`ifndef ICSP_SERIAL_PROGRAMMER_MASTER_TOP_DEFINES_SVH
`define ICSP_SERIAL_PROGRAMMER_MASTER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define ICSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: implication failed");

// Next-cycle implication, checked out of reset.
`define ICSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: next-cycle implication failed");

`endif

// File: rtl/icsp_pkg.sv
// Types, constants and command table of the serial programming master.
`timescale 1ns / 1ps
package icsp_pkg;

  localparam int CommandBits = 6;
  localparam int FrameBits   = 16;
  localparam int TimerW      = 16;
  localparam int WordW       = 14;
  localparam int ReadDataW   = 8;
  localparam int ReqW        = 4;
  localparam int BitIdxW     = 5;
  localparam int TicksW      = 8;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 16;

  // Configuration reset values
  localparam logic [TicksW-1:0] ClockHighRst   = 8'd10;
  localparam logic [TicksW-1:0] ClockLowRst    = 8'd10;
  localparam logic [TimerW-1:0] GapRst         = 16'd16;
  localparam logic [TimerW-1:0] ProgramWaitRst = 16'd16000;

  typedef enum logic [2:0] {
    PhIdle, PhCmdHi, PhCmdLo, PhCmdGap, PhFrmHi, PhFrmLo, PhFrmGap, PhWait
  } phase_e;

  typedef enum logic [ReqW-1:0] {
    ReqNone         = 4'd0,
    ReqLoadConfig   = 4'd1,
    ReqLoadProgram  = 4'd2,
    ReqLoadData     = 4'd3,
    ReqIncAddress   = 4'd4,
    ReqReadProgram  = 4'd5,
    ReqReadData     = 4'd6,
    ReqBeginProgram = 4'd7,
    ReqEraseProgram = 4'd8,
    ReqEraseData    = 4'd9
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgClockHigh, CfgClockLow, CfgGap, CfgProgramWait
  } cfg_idx_e;

  // Target command codes
  localparam logic [CommandBits-1:0] CmdLoadConfig   = 6'h00;
  localparam logic [CommandBits-1:0] CmdLoadProgram  = 6'h02;
  localparam logic [CommandBits-1:0] CmdLoadData     = 6'h03;
  localparam logic [CommandBits-1:0] CmdIncAddress   = 6'h06;
  localparam logic [CommandBits-1:0] CmdReadProgram  = 6'h04;
  localparam logic [CommandBits-1:0] CmdReadData     = 6'h05;
  localparam logic [CommandBits-1:0] CmdBeginProgram = 6'h08;
  localparam logic [CommandBits-1:0] CmdEraseProgram = 6'h09;
  localparam logic [CommandBits-1:0] CmdEraseData    = 6'h0b;

  typedef struct packed {
    logic [TicksW-1:0] clock_high;
    logic [TicksW-1:0] clock_low;
    logic [TimerW-1:0] gap;
    logic [TimerW-1:0] program_wait;
  } cfg_t;

  typedef struct packed {
    logic             clock_pin;
    logic             data_pin_out;
    logic             data_pin_drive;
    logic             busy_res;
    logic             read_valid;
    logic [WordW-1:0] read_word;
  } res_t;

  function automatic logic [CommandBits-1:0] cmd_code(req_e op);
    logic [CommandBits-1:0] code;
    case (op)
      ReqLoadConfig:   code = CmdLoadConfig;
      ReqLoadProgram:  code = CmdLoadProgram;
      ReqLoadData:     code = CmdLoadData;
      ReqIncAddress:   code = CmdIncAddress;
      ReqReadProgram:  code = CmdReadProgram;
      ReqReadData:     code = CmdReadData;
      ReqBeginProgram: code = CmdBeginProgram;
      ReqEraseProgram: code = CmdEraseProgram;
      ReqEraseData:    code = CmdEraseData;
      default:         code = '0;
    endcase
    return code;
  endfunction

  function automatic logic is_read(req_e op);
    return (op == ReqReadProgram) || (op == ReqReadData);
  endfunction

  function automatic logic is_load(req_e op);
    return (op == ReqLoadConfig) || (op == ReqLoadProgram) || (op == ReqLoadData);
  endfunction

endpackage

// File: rtl/icsp_channels_if.sv
// Valid/ready channel interfaces for request ticks and pin results.
`timescale 1ns / 1ps
interface icsp_req_if;
  import icsp_pkg::*;

  logic                valid;
  logic                ready;
  logic [ReqW-1:0]     req_type;
  logic [WordW-1:0]    write_word;
  logic                data_pin_sample;

  modport source (output valid, req_type, write_word, data_pin_sample, input ready);
  modport sink   (input valid, req_type, write_word, data_pin_sample, output ready);
endinterface

interface icsp_res_if;
  import icsp_pkg::*;

  logic             valid;
  logic             ready;
  logic             clock_pin;
  logic             data_pin_out;
  logic             data_pin_drive;
  logic             busy_res;
  logic             read_valid;
  logic [WordW-1:0] read_word;

  modport source (output valid, clock_pin, data_pin_out, data_pin_drive, busy_res,
                  read_valid, read_word, input ready);
  modport sink   (input valid, clock_pin, data_pin_out, data_pin_drive, busy_res,
                  read_valid, read_word, output ready);
endinterface

// File: rtl/icsp_cfg_regs.sv
// Configuration register file of the serial programming master.
`timescale 1ns / 1ps
module icsp_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [icsp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [icsp_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output icsp_pkg::cfg_t                 cfg_o
);
  import icsp_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Update the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgClockHigh:   cfg_d.clock_high   = cfg_wdata_i[TicksW-1:0];
        CfgClockLow:    cfg_d.clock_low    = cfg_wdata_i[TicksW-1:0];
        CfgGap:         cfg_d.gap          = cfg_wdata_i[TimerW-1:0];
        CfgProgramWait: cfg_d.program_wait = cfg_wdata_i[TimerW-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.clock_high   <= ClockHighRst;
      cfg_q.clock_low    <= ClockLowRst;
      cfg_q.gap          <= GapRst;
      cfg_q.program_wait <= ProgramWaitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/icsp_seq.sv
// Pin sequencer: state registers and one-tick next-state logic.
`timescale 1ns / 1ps
module icsp_seq (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [icsp_pkg::ReqW-1:0]   req_type_i,
  input  logic [icsp_pkg::WordW-1:0]  write_word_i,
  input  logic                        data_pin_sample_i,
  input  icsp_pkg::cfg_t              cfg_i,
  output icsp_pkg::res_t              res_o
);
  import icsp_pkg::*;

  typedef struct packed {
    phase_e               phase;
    req_e                 op;
    logic [BitIdxW-1:0]   bit_idx;
    logic [FrameBits-1:0] send;
    logic [FrameBits-1:0] recv;
    logic [TimerW-1:0]    tick;
    logic                 clk;
    logic                 dat;
    logic                 drv;
  } seq_t;

  seq_t st_q, st_d;
  logic done;

  // Clock half-period length; zero counts as one tick
  function automatic logic [TimerW-1:0] span1(logic [TicksW-1:0] v);
    return (v == '0) ? TimerW'(1) : TimerW'(v);
  endfunction

  // Raise the clock for the current frame bit
  function automatic seq_t frame_high(seq_t s, cfg_t c);
    seq_t r;
    r = s;
    r.clk = 1'b1;
    if (is_read(s.op)) begin
      r.dat = 1'b0;
      r.drv = 1'b0;
    end else begin
      r.dat = s.send[0];
      r.drv = 1'b1;
    end
    r.phase = PhFrmHi;
    r.tick  = span1(c.clock_high);
    return r;
  endfunction

  // Finish the current phase and enter the next one
  function automatic seq_t leave(seq_t s, logic sample, cfg_t c);
    seq_t                   r;
    logic [BitIdxW-1:0]     nb;
    logic [CommandBits-1:0] code;
    r    = s;
    nb   = s.bit_idx + BitIdxW'(1);
    code = cmd_code(s.op);
    case (s.phase)
      PhCmdHi: begin
        r.clk   = 1'b0;
        r.phase = PhCmdLo;
        r.tick  = span1(c.clock_low);
      end
      PhCmdLo: begin
        r.bit_idx = nb;
        if (nb < BitIdxW'(CommandBits)) begin
          r.clk   = 1'b1;
          r.drv   = 1'b1;
          r.dat   = code[nb[2:0]];
          r.phase = PhCmdHi;
          r.tick  = span1(c.clock_high);
        end else begin
          r.clk   = 1'b0;
          r.dat   = 1'b0;
          r.drv   = 1'b1;
          r.phase = PhCmdGap;
          r.tick  = c.gap;
        end
      end
      PhCmdGap: begin
        r.bit_idx = '0;
        if (is_load(s.op) || is_read(s.op)) begin
          r.recv = '0;
          r      = frame_high(r, c);
        end else if (s.op == ReqBeginProgram) begin
          r.phase = PhWait;
          r.tick  = c.program_wait;
        end else begin
          r.phase = PhIdle;
          r.tick  = '0;
        end
      end
      PhFrmHi: begin
        if (is_read(s.op)) begin
          r.recv = {sample, s.recv[FrameBits-1:1]};
        end
        r.clk   = 1'b0;
        r.phase = PhFrmLo;
        r.tick  = span1(c.clock_low);
      end
      PhFrmLo: begin
        r.bit_idx = nb;
        r.send    = {1'b0, s.send[FrameBits-1:1]};
        if (nb < BitIdxW'(FrameBits)) begin
          r = frame_high(r, c);
        end else begin
          // Drop start and stop bits; read data keeps the low byte only
          if (s.op == ReqReadData) begin
            r.recv = FrameBits'(s.recv[ReadDataW:1]);
          end else if (s.op == ReqReadProgram) begin
            r.recv = FrameBits'(s.recv[WordW:1]);
          end
          r.clk   = 1'b0;
          r.dat   = 1'b0;
          r.drv   = 1'b1;
          r.phase = PhFrmGap;
          r.tick  = c.gap;
        end
      end
      default: begin
        r.phase = PhIdle;
        r.tick  = '0;
      end
    endcase
    return r;
  endfunction

  // Advance one tick; zero-length gaps and waits fall through in the same tick
  always_comb begin
    seq_t                   s;
    logic [CommandBits-1:0] code;
    s    = st_q;
    done = 1'b0;
    code = cmd_code(req_e'(req_type_i));
    if (step_i) begin
      if (st_q.phase == PhIdle) begin
        if (req_type_i >= ReqLoadConfig && req_type_i <= ReqEraseData) begin
          s.op      = req_e'(req_type_i);
          s.bit_idx = '0;
          s.send    = {1'b0, write_word_i, 1'b0};
          s.clk     = 1'b1;
          s.drv     = 1'b1;
          s.dat     = code[0];
          s.phase   = PhCmdHi;
          s.tick    = span1(cfg_i.clock_high);
        end
      end else begin
        s.tick = (st_q.tick != '0) ? st_q.tick - TimerW'(1) : '0;
        if (s.tick == '0) begin
          done = (st_q.phase == PhFrmLo) && is_read(st_q.op) &&
                 (st_q.bit_idx == BitIdxW'(FrameBits - 1));
          s = leave(s, data_pin_sample_i, cfg_i);
          if (s.phase != PhIdle && s.tick == '0) begin
            s = leave(s, data_pin_sample_i, cfg_i);
          end
          if (s.phase != PhIdle && s.tick == '0) begin
            s = leave(s, data_pin_sample_i, cfg_i);
          end
        end
      end
    end
    st_d = s;
  end

  // Pin levels after this tick's update
  always_comb begin
    res_o.clock_pin      = st_d.clk;
    res_o.data_pin_out   = st_d.dat;
    res_o.data_pin_drive = st_d.drv;
    res_o.busy_res       = (st_d.phase != PhIdle);
    res_o.read_valid     = done;
    res_o.read_word      = done ? st_d.recv[WordW-1:0] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase   <= PhIdle;
      st_q.op      <= ReqNone;
      st_q.bit_idx <= '0;
      st_q.send    <= '0;
      st_q.recv    <= '0;
      st_q.tick    <= '0;
      st_q.clk     <= 1'b0;
      st_q.dat     <= 1'b0;
      st_q.drv     <= 1'b1;
    end else begin
      st_q <= st_d;
    end
  end

endmodule

// File: rtl/icsp_serial_programmer_master_top.sv
// Top level of the serial programming master: input register, sequencer, result register.
//
// Usage:
//   req_i carries one timer tick per word: an optional operation request,
//   the word to load and the sampled data pin. res_o returns one word per
//   tick with the clock and data pin levels, the busy flag and, on the tick
//   a read finishes, the word read.
//   An accepted tick is registered, evaluated against the sequencer state
//   when the result register is free, and its result is registered there.
//   Throughput: one tick per clock cycle while res_o is taken; the pin
//   sequencer updates its state and the result register in the same cycle.
//   Stall: when res_o is not taken the result register holds, the input
//   register fills, and req_i.ready drops until the result moves on. No
//   tick is lost or repeated, so pin timing counts accepted ticks only.
//   Configuration: cfg_we_i writes register cfg_idx_i (clock high, clock
//   low, gap, program wait) from cfg_wdata_i; write only while idle.
//   Reset: both stages empty, sequencer idle, clock low, data low and
//   driven, configuration at its default timing.
`timescale 1ns / 1ps
module icsp_serial_programmer_master_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  icsp_req_if.sink                       req_i,
  icsp_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [icsp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [icsp_pkg::CfgDataW-1:0]  cfg_wdata_i
);
  import icsp_pkg::*;

  cfg_t             cfg;
  res_t             res_d, res_q;
  logic             in_v_q, in_v_d;
  logic             out_v_q, out_v_d;
  logic [ReqW-1:0]  req_type_q;
  logic [WordW-1:0] write_word_q;
  logic             sample_q;
  logic             in_take, step, out_free;

  // Handshake control of both stages
  assign out_free    = !out_v_q || res_o.ready;
  assign step        = in_v_q && out_free;
  assign req_i.ready = !in_v_q || step;
  assign in_take     = req_i.valid && req_i.ready;

  assign in_v_d  = in_take ? 1'b1 : (step ? 1'b0 : in_v_q);
  assign out_v_d = step ? 1'b1 : (res_o.ready ? 1'b0 : out_v_q);

  icsp_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  icsp_seq u_seq (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (step),
    .req_type_i        (req_type_q),
    .write_word_i      (write_word_q),
    .data_pin_sample_i (sample_q),
    .cfg_i             (cfg),
    .res_o             (res_d)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= in_v_d;
      out_v_q <= out_v_d;
    end
  end

  // Capture the incoming word
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      req_type_q   <= req_i.req_type;
      write_word_q <= req_i.write_word;
      sample_q     <= req_i.data_pin_sample;
    end
  end

  // Capture the result word
  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.clock_pin      = res_q.clock_pin;
  assign res_o.data_pin_out   = res_q.data_pin_out;
  assign res_o.data_pin_drive = res_q.data_pin_drive;
  assign res_o.busy_res       = res_q.busy_res;
  assign res_o.read_valid     = res_q.read_valid;
  assign res_o.read_word      = res_q.read_word;

endmodule

// File: rtl/icsp_checker.sv
// Port-level checker of the serial programming master, bound to the top level.
`timescale 1ns / 1ps
`include "icsp_serial_programmer_master_top_defines.svh"
module icsp_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         res_valid_i,
  input logic                         res_ready_i,
  input logic                         clock_pin_i,
  input logic                         data_pin_out_i,
  input logic                         data_pin_drive_i,
  input logic                         busy_res_i,
  input logic                         read_valid_i,
  input logic [icsp_pkg::WordW-1:0]   read_word_i
);
  import icsp_pkg::*;

  logic [WordW+4:0] payload;
  assign payload = {clock_pin_i, data_pin_out_i, data_pin_drive_i, busy_res_i,
                    read_valid_i, read_word_i};

  // A stalled result word holds
  `ICSP_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, res_valid_i && !res_ready_i, res_valid_i && $stable(payload))

  // A finished read leaves the clock low and the data pin driven low
  `ICSP_ASSERT_IMP(a_read_end_pins, clk_i, rst_ni, res_valid_i && read_valid_i, !clock_pin_i && data_pin_drive_i && !data_pin_out_i)

  // The data pin is released only inside an operation
  `ICSP_ASSERT_IMP(a_release_busy, clk_i, rst_ni, res_valid_i && !data_pin_drive_i, busy_res_i)

  // The clock is raised only inside an operation
  `ICSP_ASSERT_IMP(a_clock_busy, clk_i, rst_ni, res_valid_i && clock_pin_i, busy_res_i)

  // No read word without a finished read
  `ICSP_ASSERT_IMP(a_word_zero, clk_i, rst_ni, res_valid_i && !read_valid_i, read_word_i == '0)

endmodule

bind icsp_serial_programmer_master_top icsp_checker u_icsp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .clock_pin_i      (res_o.clock_pin),
  .data_pin_out_i   (res_o.data_pin_out),
  .data_pin_drive_i (res_o.data_pin_drive),
  .busy_res_i       (res_o.busy_res),
  .read_valid_i     (res_o.read_valid),
  .read_word_i      (res_o.read_word)
);
